[hw/rtl/llgcd_pkg.sv]
package llgcd_pkg;

  // Fixed-point format and field widths
  localparam int FRAC        = 20;
  localparam int MAG_W       = 22;
  localparam int AXIS_W      = 22;
  localparam int GAIN_W      = 24;
  localparam int DAMP_W      = 21;
  localparam int FIELD_WIDTH = 24;

  // Configuration port
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_AXIS_X  = 3'd0,
    REG_AXIS_Y  = 3'd1,
    REG_AXIS_Z  = 3'd2,
    REG_GAIN    = 3'd3,
    REG_DAMPING = 3'd4
  } reg_index_t;

  // Effective field datapath widths
  localparam int AM_W   = MAG_W + AXIS_W;
  localparam int DSUM_W = AM_W + 2;
  localparam int DOT_W  = DSUM_W - FRAC;
  localparam int GP_W   = GAIN_W + DOT_W;
  localparam int G_W    = GP_W - FRAC;
  localparam int GA_W   = G_W + AXIS_W;
  localparam int GS_W   = GA_W - FRAC;
  localparam int H_W    = ((GS_W > FIELD_WIDTH) ? GS_W : FIELD_WIDTH) + 1;

  // Torque datapath widths
  localparam int MP_W   = 2 * MAG_W;
  localparam int MM_W   = MP_W - FRAC;
  localparam int HM_W   = H_W + MAG_W;
  localparam int PD_W   = HM_W + 1;
  localparam int PREC_W = PD_W - FRAC;
  localparam int HD_W   = H_W + MM_W;
  localparam int DS_W   = HD_W + 2;
  localparam int D_W    = DS_W - FRAC;
  localparam int AP_W   = D_W + DAMP_W + 1;
  localparam int AD_W   = AP_W - FRAC;
  localparam int RS_W   = ((AD_W > PREC_W) ? AD_W : PREC_W) + 1;

  // Cycles from an accepted start to its done strobe
  localparam int LATENCY = 10;

  typedef struct packed {
    logic signed [AXIS_W-1:0] axis_x;
    logic signed [AXIS_W-1:0] axis_y;
    logic signed [AXIS_W-1:0] axis_z;
    logic signed [GAIN_W-1:0] aniso_gain;
    logic        [DAMP_W-1:0] damping;
  } cfg_t;

  typedef struct packed {
    logic                    valid;
    logic signed [H_W-1:0]   hx;
    logic signed [H_W-1:0]   hy;
    logic signed [H_W-1:0]   hz;
    logic signed [MAG_W-1:0] mx;
    logic signed [MAG_W-1:0] my;
    logic signed [MAG_W-1:0] mz;
  } heff_beat_t;

endpackage

[hw/rtl/llgcd_cfg.sv]
module llgcd_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [llgcd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [llgcd_pkg::CFG_DATA_W-1:0]   cfg_data,
  output llgcd_pkg::cfg_t                    cfg
);
  import llgcd_pkg::*;

  logic wr_en;

  assign wr_en = cfg_valid & cfg_ready;

  // Hold register values; decode the index on each write beat, ignore unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.axis_x     <= AXIS_W'(1830);
      cfg.axis_y     <= AXIS_W'(3);
      cfg.axis_z     <= AXIS_W'(1048574);
      cfg.aniso_gain <= -GAIN_W'(263535);
      cfg.damping    <= DAMP_W'(10486);
    end else if (wr_en) begin
      unique case (reg_index_t'(cfg_index))
        REG_AXIS_X:  cfg.axis_x     <= cfg_data[AXIS_W-1:0];
        REG_AXIS_Y:  cfg.axis_y     <= cfg_data[AXIS_W-1:0];
        REG_AXIS_Z:  cfg.axis_z     <= cfg_data[AXIS_W-1:0];
        REG_GAIN:    cfg.aniso_gain <= cfg_data[GAIN_W-1:0];
        REG_DAMPING: cfg.damping    <= cfg_data[DAMP_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[hw/rtl/llgcd_field.sv]
module llgcd_field (
  input  logic                                   clk,
  input  logic                                   rst,
  input  llgcd_pkg::cfg_t                        cfg,
  input  logic                                   in_valid,
  input  logic signed [llgcd_pkg::MAG_W-1:0]     mag_x,
  input  logic signed [llgcd_pkg::MAG_W-1:0]     mag_y,
  input  logic signed [llgcd_pkg::MAG_W-1:0]     mag_z,
  input  logic signed [llgcd_pkg::FIELD_WIDTH-1:0] field_x,
  input  logic signed [llgcd_pkg::FIELD_WIDTH-1:0] field_y,
  input  logic signed [llgcd_pkg::FIELD_WIDTH-1:0] field_z,
  output llgcd_pkg::heff_beat_t                  heff
);
  import llgcd_pkg::*;

  logic v1, v2, v3, v4, v5;

  logic signed [MAG_W-1:0]       m1 [3];
  logic signed [MAG_W-1:0]       m2 [3];
  logic signed [MAG_W-1:0]       m3 [3];
  logic signed [MAG_W-1:0]       m4 [3];
  logic signed [MAG_W-1:0]       m5 [3];
  logic signed [FIELD_WIDTH-1:0] f1 [3];
  logic signed [FIELD_WIDTH-1:0] f2 [3];
  logic signed [FIELD_WIDTH-1:0] f3 [3];
  logic signed [FIELD_WIDTH-1:0] f4 [3];

  logic signed [AM_W-1:0]   am_x, am_y, am_z;
  logic signed [DSUM_W-1:0] dot_sum;
  logic signed [DOT_W-1:0]  dot;
  logic signed [GP_W-1:0]   g_prod;
  logic signed [G_W-1:0]    g;
  logic signed [GA_W-1:0]   ga_x, ga_y, ga_z;
  logic signed [GS_W-1:0]   gs_x, gs_y, gs_z;
  logic signed [H_W-1:0]    h5 [3];

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // Stage 1: axis times magnetization products
  always_ff @(posedge clk) begin
    am_x  <= cfg.axis_x * mag_x;
    am_y  <= cfg.axis_y * mag_y;
    am_z  <= cfg.axis_z * mag_z;
    m1[0] <= mag_x;
    m1[1] <= mag_y;
    m1[2] <= mag_z;
    f1[0] <= field_x;
    f1[1] <= field_y;
    f1[2] <= field_z;
  end

  // Stage 2: dot product a.m, truncated
  assign dot_sum = DSUM_W'(am_x) + DSUM_W'(am_y) + DSUM_W'(am_z);

  always_ff @(posedge clk) begin
    dot <= dot_sum[DSUM_W-1:FRAC];
    m2  <= m1;
    f2  <= f1;
  end

  // Stage 3: scale by the anisotropy gain
  assign g_prod = cfg.aniso_gain * dot;

  always_ff @(posedge clk) begin
    g  <= g_prod[GP_W-1:FRAC];
    m3 <= m2;
    f3 <= f2;
  end

  // Stage 4: project back onto the easy axis
  always_ff @(posedge clk) begin
    ga_x <= g * cfg.axis_x;
    ga_y <= g * cfg.axis_y;
    ga_z <= g * cfg.axis_z;
    m4   <= m3;
    f4   <= f3;
  end

  // Stage 5: add the applied field
  assign gs_x = ga_x[GA_W-1:FRAC];
  assign gs_y = ga_y[GA_W-1:FRAC];
  assign gs_z = ga_z[GA_W-1:FRAC];

  always_ff @(posedge clk) begin
    h5[0] <= H_W'(f4[0]) + H_W'(gs_x);
    h5[1] <= H_W'(f4[1]) + H_W'(gs_y);
    h5[2] <= H_W'(f4[2]) + H_W'(gs_z);
    m5    <= m4;
  end

  assign heff = '{valid: v5,
                  hx: h5[0], hy: h5[1], hz: h5[2],
                  mx: m5[0], my: m5[1], mz: m5[2]};

endmodule

[hw/rtl/llgcd_torque.sv]
module llgcd_torque (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic [llgcd_pkg::DAMP_W-1:0]             damping,
  input  llgcd_pkg::heff_beat_t                    heff,
  output logic                                     done,
  output logic signed [llgcd_pkg::FIELD_WIDTH-1:0] rate_x,
  output logic signed [llgcd_pkg::FIELD_WIDTH-1:0] rate_y,
  output logic signed [llgcd_pkg::FIELD_WIDTH-1:0] rate_z
);
  import llgcd_pkg::*;

  localparam logic signed [RS_W-1:0] SAT_HI = RS_W'((64'sd1 <<< (FIELD_WIDTH - 1)) - 64'sd1);
  localparam logic signed [RS_W-1:0] SAT_LO = RS_W'(-(64'sd1 <<< (FIELD_WIDTH - 1)));

  function automatic logic signed [FIELD_WIDTH-1:0] sat(input logic signed [RS_W-1:0] v);
    logic signed [RS_W-1:0] c;
    c = v;
    if (v > SAT_HI) c = SAT_HI;
    if (v < SAT_LO) c = SAT_LO;
    return c[FIELD_WIDTH-1:0];
  endfunction

  logic v1, v2, v3, v4;

  logic signed [MP_W-1:0]   p_xx, p_yy, p_zz, p_xy, p_xz, p_yz;
  logic signed [MM_W-1:0]   mm_xx, mm_yy, mm_zz, mm_xy, mm_xz, mm_yz;
  logic signed [HM_W-1:0]   hy_mz, hz_my, hz_mx, hx_mz, hx_my, hy_mx;
  logic signed [H_W-1:0]    h1 [3];

  logic signed [PD_W-1:0]   pd [3];
  logic signed [PREC_W-1:0] prec2 [3];
  logic signed [PREC_W-1:0] prec3 [3];
  logic signed [PREC_W-1:0] prec4 [3];
  logic signed [HD_W-1:0]   dpx [4];
  logic signed [HD_W-1:0]   dpy [4];
  logic signed [HD_W-1:0]   dpz [4];

  logic signed [DS_W-1:0]   ds [3];
  logic signed [D_W-1:0]    d [3];
  logic signed [DAMP_W:0]   alpha_s;
  logic signed [AP_W-1:0]   ap [3];
  logic signed [AD_W-1:0]   ad [3];
  logic signed [RS_W-1:0]   rs [3];

  // Valid bits travel with the data; done is the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= heff.valid;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      done <= v4;
    end
  end

  // Stage 1: magnetization pair products and precession products
  assign p_xx = heff.mx * heff.mx;
  assign p_yy = heff.my * heff.my;
  assign p_zz = heff.mz * heff.mz;
  assign p_xy = heff.mx * heff.my;
  assign p_xz = heff.mx * heff.mz;
  assign p_yz = heff.my * heff.mz;

  always_ff @(posedge clk) begin
    mm_xx <= p_xx[MP_W-1:FRAC];
    mm_yy <= p_yy[MP_W-1:FRAC];
    mm_zz <= p_zz[MP_W-1:FRAC];
    mm_xy <= p_xy[MP_W-1:FRAC];
    mm_xz <= p_xz[MP_W-1:FRAC];
    mm_yz <= p_yz[MP_W-1:FRAC];
    hy_mz <= heff.hy * heff.mz;
    hz_my <= heff.hz * heff.my;
    hz_mx <= heff.hz * heff.mx;
    hx_mz <= heff.hx * heff.mz;
    hx_my <= heff.hx * heff.my;
    hy_mx <= heff.hy * heff.mx;
    h1[0] <= heff.hx;
    h1[1] <= heff.hy;
    h1[2] <= heff.hz;
  end

  // Stage 2: finish the cross product H x m, form the damping products
  assign pd[0] = PD_W'(hy_mz) - PD_W'(hz_my);
  assign pd[1] = PD_W'(hz_mx) - PD_W'(hx_mz);
  assign pd[2] = PD_W'(hx_my) - PD_W'(hy_mx);

  always_ff @(posedge clk) begin
    prec2[0] <= pd[0][PD_W-1:FRAC];
    prec2[1] <= pd[1][PD_W-1:FRAC];
    prec2[2] <= pd[2][PD_W-1:FRAC];
    dpx[0]   <= h1[1] * mm_xy;
    dpx[1]   <= h1[2] * mm_xz;
    dpx[2]   <= h1[0] * mm_yy;
    dpx[3]   <= h1[0] * mm_zz;
    dpy[0]   <= h1[0] * mm_xy;
    dpy[1]   <= h1[2] * mm_yz;
    dpy[2]   <= h1[1] * mm_xx;
    dpy[3]   <= h1[1] * mm_zz;
    dpz[0]   <= h1[0] * mm_xz;
    dpz[1]   <= h1[1] * mm_yz;
    dpz[2]   <= h1[2] * mm_xx;
    dpz[3]   <= h1[2] * mm_yy;
  end

  // Stage 3: sum the double cross product m x (m x H)
  assign ds[0] = DS_W'(dpx[0]) + DS_W'(dpx[1]) - DS_W'(dpx[2]) - DS_W'(dpx[3]);
  assign ds[1] = DS_W'(dpy[0]) + DS_W'(dpy[1]) - DS_W'(dpy[2]) - DS_W'(dpy[3]);
  assign ds[2] = DS_W'(dpz[0]) + DS_W'(dpz[1]) - DS_W'(dpz[2]) - DS_W'(dpz[3]);

  always_ff @(posedge clk) begin
    d[0]  <= ds[0][DS_W-1:FRAC];
    d[1]  <= ds[1][DS_W-1:FRAC];
    d[2]  <= ds[2][DS_W-1:FRAC];
    prec3 <= prec2;
  end

  // Stage 4: scale by alpha
  assign alpha_s = $signed({1'b0, damping});
  assign ap[0]   = alpha_s * d[0];
  assign ap[1]   = alpha_s * d[1];
  assign ap[2]   = alpha_s * d[2];

  always_ff @(posedge clk) begin
    ad[0] <= ap[0][AP_W-1:FRAC];
    ad[1] <= ap[1][AP_W-1:FRAC];
    ad[2] <= ap[2][AP_W-1:FRAC];
    prec4 <= prec3;
  end

  // Stage 5: subtract damping term and saturate into the output register
  assign rs[0] = RS_W'(prec4[0]) - RS_W'(ad[0]);
  assign rs[1] = RS_W'(prec4[1]) - RS_W'(ad[1]);
  assign rs[2] = RS_W'(prec4[2]) - RS_W'(ad[2]);

  always_ff @(posedge clk) begin
    rate_x <= sat(rs[0]);
    rate_y <= sat(rs[1]);
    rate_z <= sat(rs[2]);
  end

endmodule

[hw/rtl/llg_cartesian_derivative.sv]
// Landau-Lifshitz-Gilbert derivative, Cartesian form, Q3.20 fixed point for fields and rates, Q1.20 for magnetization.
// Command channel: present mag_x/y/z and field_x/y/z with start; the beat is
// taken at a rising edge where start is high and busy is low. busy is low at
// all times outside reset, so a new vector can be taken every cycle.
// Result channel: rate_x/y/z are valid for exactly one cycle while done is
// high, in start order, once the start beat has passed the ten register
// stages of the multiply-add datapath (five for the effective field, five
// for the torque and damping terms). Throughput is one vector per clock.
// The receiver has no backpressure: it must take each result in its done
// cycle.
// Configuration channel: cfg_index selects axis_x, axis_y, axis_z,
// aniso_gain or damping; cfg_data is written when cfg_valid and cfg_ready
// are high. Unknown indexes are dropped. Write only while the pipeline is
// empty.
// Reset (rst, synchronous, active high) restores the default register
// values and drops every vector in flight; no done strobe follows.
module llg_cartesian_derivative (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     start,
  output logic                                     busy,
  input  logic signed [llgcd_pkg::MAG_W-1:0]       mag_x,
  input  logic signed [llgcd_pkg::MAG_W-1:0]       mag_y,
  input  logic signed [llgcd_pkg::MAG_W-1:0]       mag_z,
  input  logic signed [llgcd_pkg::FIELD_WIDTH-1:0] field_x,
  input  logic signed [llgcd_pkg::FIELD_WIDTH-1:0] field_y,
  input  logic signed [llgcd_pkg::FIELD_WIDTH-1:0] field_z,
  output logic                                     done,
  output logic signed [llgcd_pkg::FIELD_WIDTH-1:0] rate_x,
  output logic signed [llgcd_pkg::FIELD_WIDTH-1:0] rate_y,
  output logic signed [llgcd_pkg::FIELD_WIDTH-1:0] rate_z,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [llgcd_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [llgcd_pkg::CFG_DATA_W-1:0]         cfg_data
);
  import llgcd_pkg::*;

  cfg_t       cfg;
  heff_beat_t heff;
  logic       accept;

  // Take a beat every cycle outside reset
  assign busy      = rst;
  assign cfg_ready = ~rst;
  assign accept    = start & ~busy;

  llgcd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  llgcd_field u_field (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (accept),
    .mag_x    (mag_x),
    .mag_y    (mag_y),
    .mag_z    (mag_z),
    .field_x  (field_x),
    .field_y  (field_y),
    .field_z  (field_z),
    .heff     (heff)
  );

  llgcd_torque u_torque (
    .clk     (clk),
    .rst     (rst),
    .damping (cfg.damping),
    .heff    (heff),
    .done    (done),
    .rate_x  (rate_x),
    .rate_y  (rate_y),
    .rate_z  (rate_z)
  );

endmodule

[hw/rtl/llgcd_checker.sv]
module llgcd_checker (
  input logic                                     clk,
  input logic                                     rst,
  input logic                                     start,
  input logic                                     busy,
  input logic                                     done,
  input logic signed [llgcd_pkg::FIELD_WIDTH-1:0] rate_x,
  input logic                                     cfg_ready
);
  import llgcd_pkg::*;

  // Reset flushes the pipeline: no result in the following cycle
  a_reset_flush: assert property (@(posedge clk) rst |=> !done)
    else $error("done strobe right after reset");

  // Every accepted command yields a result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("result missing after accepted start");

  // No result appears without a command accepted the latency before
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("done strobe without matching start");

  // Outside reset both channels are always open
  a_open: assert property (@(posedge clk) disable iff (rst)
    !busy && cfg_ready)
    else $error("channel closed outside reset");

  // A result beat carries known data
  a_known_rate: assert property (@(posedge clk) disable iff (rst)
    done |-> !$isunknown(rate_x))
    else $error("unknown rate on a done strobe");

endmodule

bind llg_cartesian_derivative llgcd_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .rate_x    (rate_x),
  .cfg_ready (cfg_ready)
);
